[design/ritf_pkg.sv]
package ritf_pkg;

	localparam int DIGIT_SLOTS_DEF = 32;
	localparam int MAX_WIDTH_DEF   = 64;

	localparam int FLAG_ZEROPAD = 0;
	localparam int FLAG_SIGNED  = 1;
	localparam int FLAG_PLUS    = 2;
	localparam int FLAG_SPACE   = 3;
	localparam int FLAG_LEFT    = 4;
	localparam int FLAG_PREFIX  = 5;
	localparam int FLAG_LOWER   = 6;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] RADIX_HEX = 6'd16;
	localparam logic [5:0] RADIX_OCT = 6'd8;

	localparam logic [7:0] CH_NONE  = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_A_LO  = 8'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_BOUND,
		ST_EMIT
	} ritf_state_t;

	typedef struct packed {
		logic ld_in;
		logic ld_err;
		logic div_step;
		logic prep;
		logic bound;
		logic emit;
	} ritf_cmd_t;

	typedef struct packed {
		logic bad_in;
		logic div_done;
		logic emit_end;
	} ritf_stat_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
		logic [7:0] base;
		base = lower ? CH_A_LO : CH_A_UP;
		if (d < 6'd10)
			return CH_ZERO + {2'b00, d};
		else
			return base + {2'b00, d} - 8'd10;
	endfunction

endpackage

[design/ritf_ctrl.sv]
module ritf_ctrl
	import ritf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  ritf_stat_t stat,
	output ritf_cmd_t  cmd
);

	ritf_state_t state_q;
	ritf_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !slot_free;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && !stat.bad_in) state_d = ST_DIV;
			ST_DIV:   if (stat.div_done) state_d = ST_PREP;
			ST_PREP:  state_d = ST_BOUND;
			ST_BOUND: state_d = ST_EMIT;
			ST_EMIT:  if (slot_free && stat.emit_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ld_in  = accept && !stat.bad_in;
				cmd.ld_err = accept && stat.bad_in;
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_PREP:  cmd.prep = 1'b1;
			ST_BOUND: cmd.bound = 1'b1;
			ST_EMIT:  cmd.emit = slot_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_err || cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[design/ritf_dp.sv]
module ritf_dp
	import ritf_pkg::*;
#(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ritf_cmd_t   cmd,
	output ritf_stat_t  stat,
	input  logic [31:0] value,
	input  logic [5:0]  radix,
	input  logic [6:0]  width,
	input  logic [5:0]  precision,
	input  logic [6:0]  format_flags,
	output logic [7:0]  out_char,
	output logic        last,
	output logic        bad_radix
);

	localparam int AW = $clog2(DIGIT_SLOTS);
	localparam int CW = $clog2(DIGIT_SLOTS + 1);
	localparam int PW = $clog2(MAX_WIDTH);

	logic [5:0]    mem [DIGIT_SLOTS];
	logic [5:0]    rd_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] idx_d;

	logic [31:0]   quo_q;
	logic [5:0]    rem_q;
	logic [1:0]    chunk_q;
	logic [CW-1:0] dcnt_q;
	logic [5:0]    radix_q;
	logic [6:0]    width_q;
	logic [5:0]    prec_q;
	logic [7:0]    sign_q;
	logic [1:0]    pfx_q;
	logic          zp_q;
	logic          left_q;
	logic          lower_q;

	logic [6:0]    pw_q;
	logic [7:0]    sp_q;
	logic [7:0]    b1_q, b2_q, b3_q, b5_q, b6_q, total_q;
	logic [PW-1:0] pos_q;

	logic [7:0]    out_char_q;
	logic          last_q;
	logic          bad_q;

	logic [7:0]    qbits;
	logic [5:0]    rem_d;
	logic [31:0]   quo_d;
	logic          neg;
	logic [6:0]    nd7;
	logic [6:0]    pw_d;
	logic signed [8:0] size_d;
	logic [7:0]    lead, pad, trail, b1, b2, b3, b4, b5, b6;
	logic [7:0]    pe;
	logic          in_dig;
	logic [7:0]    ch;

	assign stat.bad_in = (radix < RADIX_MIN) || (radix > RADIX_MAX);

	// 8 quotient bits per cycle, restoring
	always_comb begin
		logic [6:0] rr;
		logic [5:0] r;
		r     = rem_q;
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			rr = {r, quo_q[31-i]};
			if (rr >= {1'b0, radix_q}) begin
				qbits[7-i] = 1'b1;
				r = 6'(rr - {1'b0, radix_q});
			end else begin
				r = rr[5:0];
			end
		end
		rem_d = r;
	end

	assign quo_d         = {quo_q[23:0], qbits};
	assign stat.div_done = (chunk_q == 2'd3) && (quo_d == 32'd0);

	assign neg = format_flags[FLAG_SIGNED] && value[31];

	assign nd7    = 7'(dcnt_q);
	assign pw_d   = ({1'b0, prec_q} > nd7) ? {1'b0, prec_q} : nd7;
	assign size_d = $signed({2'b00, width_q}) - $signed({8'd0, (sign_q != CH_NONE)})
		- $signed({7'd0, pfx_q}) - $signed({2'b00, pw_d});

	assign lead  = (!zp_q && !left_q) ? sp_q : 8'd0;
	assign pad   = zp_q ? sp_q : 8'd0;
	assign trail = left_q ? sp_q : 8'd0;
	assign b1    = lead;
	assign b2    = b1 + {7'd0, (sign_q != CH_NONE)};
	assign b3    = b2 + {6'd0, pfx_q};
	assign b4    = b3 + pad;
	assign b5    = b4 + {1'b0, pw_q} - {1'b0, nd7};
	assign b6    = b5 + {1'b0, nd7};

	assign pe            = 8'(pos_q);
	assign in_dig        = (pe >= b5_q) && (pe < b6_q);
	assign stat.emit_end = (pe == total_q - 8'd1) || (pos_q == PW'(MAX_WIDTH - 1));

	always_comb begin
		if (pe < b1_q)
			ch = CH_SPACE;
		else if (pe < b2_q)
			ch = sign_q;
		else if (pe < b3_q)
			ch = (pe == b2_q) ? CH_ZERO : (lower_q ? CH_X_LO : CH_X_UP);
		else if (pe < b5_q)
			ch = CH_ZERO;
		else if (pe < b6_q)
			ch = digit_char(rd_q, lower_q);
		else
			ch = CH_SPACE;
	end

	always_comb begin
		idx_d = idx_q;
		if (cmd.prep)
			idx_d = AW'(dcnt_q - CW'(1));
		else if (cmd.emit && in_dig)
			idx_d = idx_q - AW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && chunk_q == 2'd3 && dcnt_q < CW'(DIGIT_SLOTS))
			mem[dcnt_q[AW-1:0]] <= rem_d;
		rd_q <= mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			dcnt_q  <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.ld_in) begin
				chunk_q <= '0;
				dcnt_q  <= '0;
			end else if (cmd.div_step) begin
				chunk_q <= chunk_q + 2'd1;
				if (chunk_q == 2'd3 && dcnt_q < CW'(DIGIT_SLOTS))
					dcnt_q <= dcnt_q + CW'(1);
			end
			if (cmd.bound)
				pos_q <= '0;
			else if (cmd.emit)
				pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			quo_q   <= neg ? 32'd0 - value : value;
			rem_q   <= '0;
			radix_q <= radix;
			width_q <= width;
			prec_q  <= precision;
			zp_q    <= format_flags[FLAG_ZEROPAD] && !format_flags[FLAG_LEFT];
			left_q  <= format_flags[FLAG_LEFT];
			lower_q <= format_flags[FLAG_LOWER];
			if (neg)
				sign_q <= CH_MINUS;
			else if (format_flags[FLAG_PLUS])
				sign_q <= CH_PLUS;
			else if (format_flags[FLAG_SPACE])
				sign_q <= CH_SPACE;
			else
				sign_q <= CH_NONE;
			if (!format_flags[FLAG_PREFIX])
				pfx_q <= 2'd0;
			else if (radix == RADIX_HEX)
				pfx_q <= 2'd2;
			else if (radix == RADIX_OCT)
				pfx_q <= 2'd1;
			else
				pfx_q <= 2'd0;
		end else if (cmd.div_step) begin
			quo_q <= quo_d;
			rem_q <= (chunk_q == 2'd3) ? 6'd0 : rem_d;
		end
		if (cmd.prep) begin
			pw_q <= pw_d;
			sp_q <= (size_d > 9'sd0) ? size_d[7:0] : 8'd0;
		end
		if (cmd.bound) begin
			b1_q    <= b1;
			b2_q    <= b2;
			b3_q    <= b3;
			b5_q    <= b5;
			b6_q    <= b6;
			total_q <= b6 + trail;
		end
		if (cmd.ld_err) begin
			out_char_q <= CH_NONE;
			last_q     <= 1'b1;
			bad_q      <= 1'b1;
		end else if (cmd.emit) begin
			out_char_q <= ch;
			last_q     <= stat.emit_end;
			bad_q      <= 1'b0;
		end
	end

	assign out_char  = out_char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < radix_q)
		else $error("partial remainder not below radix");

	a_pos_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pe < total_q)
		else $error("emit position past end of text");

	a_digit_written: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && in_dig) |-> CW'(idx_q) < dcnt_q)
		else $error("digit read beyond stored digits");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && chunk_q == 2'd3 && dcnt_q < CW'(DIGIT_SLOTS))
		|=> dcnt_q == $past(dcnt_q) + CW'(1))
		else $error("digit count did not advance");

endmodule

[design/integer_radix_text_formatter.sv]
// Flow: the radix divider yields each digit by dividing the 32-bit quotient,
// 8 quotient bits a cycle, then the PREP and BOUND setup states run, then one
// character per cycle while out_stall is low. No new word is taken until the
// last character of an item is out; a bad radix word gives one bad_radix item.
// Reset: asynchronous active-low arst_n clears the controller and output valid.
module integer_radix_text_formatter
	import ritf_pkg::*;
#(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [5:0]  radix,
	input  logic [6:0]  width,
	input  logic [5:0]  precision,
	input  logic [6:0]  format_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last,
	output logic        bad_radix
);

	ritf_cmd_t  cmd;
	ritf_stat_t stat;

	ritf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ritf_dp #(
		.DIGIT_SLOTS (DIGIT_SLOTS),
		.MAX_WIDTH   (MAX_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.value        (value),
		.radix        (radix),
		.width        (width),
		.precision    (precision),
		.format_flags (format_flags),
		.out_char     (out_char),
		.last         (last),
		.bad_radix    (bad_radix)
	);

endmodule
